### rtl/rdxc_pkg.sv
// Shared types, constants and character helpers for the radix converter.
`default_nettype none

package rdxc_pkg;

   localparam int VALUE_BITS = 31;
   localparam int RADIX_W = 6;
   localparam int CHAR_W = 8;
   localparam int MIN_RADIX = 2;
   localparam int MAX_RADIX = 32;
   localparam int DIGIT_W = $clog2(MAX_RADIX);
   localparam int MAC_W = VALUE_BITS + RADIX_W;
   localparam int STEP_W = $clog2(VALUE_BITS);
   localparam int ADDR_W = $clog2(VALUE_BITS);
   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int CSR_IDX_W = 1;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
   localparam logic [CHAR_W-1:0] ASCII_NINE = 8'd57;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'd65;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'd90;
   localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd55;
   localparam logic [CHAR_W-1:0] DECIMAL_BASE = 8'd10;
   localparam logic [CHAR_W-1:0] ASCII_TOP_DIGIT = CHAR_W'(55 + MAX_RADIX - 1);

   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_RADIX = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_RADIX = 1'b1;

   typedef struct packed {
      logic               ok;
      logic [RADIX_W-1:0] value;
   } digit_type;

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      if (r < RADIX_W'(MIN_RADIX)) begin
         res = RADIX_W'(MIN_RADIX);
      end else if (r > RADIX_W'(MAX_RADIX)) begin
         res = RADIX_W'(MAX_RADIX);
      end else begin
         res = r;
      end
      return res;
   endfunction

   function automatic digit_type decode_char(input logic [CHAR_W-1:0] c);
      digit_type res;
      res.ok = 1'b0;
      res.value = '0;
      if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
         res.ok = 1'b1;
         res.value = RADIX_W'(c - ASCII_ZERO);
      end else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
         res.ok = 1'b1;
         res.value = RADIX_W'(c - LETTER_OFFSET);
      end
      return res;
   endfunction

   function automatic logic [CHAR_W-1:0] encode_digit(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] res;
      if (CHAR_W'(d) >= DECIMAL_BASE) begin
         res = CHAR_W'(d) + LETTER_OFFSET;
      end else begin
         res = CHAR_W'(d) + ASCII_ZERO;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/radix_converter.sv
// Radix converter: accumulates a digit string, then re-emits it in another radix.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   req     | req_valid/ready, digit_char, final  | in
//   rsp     | rsp_valid/ready, out_char, last,bad | out
//   csr     | csr_valid/ready, index, wdata       | in
//
// A non-final character is taken with a multiply-add on accept.
// A final character runs a shared restoring divider that writes each output
// digit to the digit store; the store is then read back out through the READ,
// LOAD and SEND states, most significant first, held by any rsp_ready stall.
// An error result is registered and comes out in the cycle after the final character.
// Synchronous reset restores both radices to 10; the digit store is not cleared.
// While rsp_ready is low the pending word holds and no character is taken.
`default_nettype none

module radix_converter (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [rdxc_pkg::CHAR_W-1:0]       req_digit_char,
   input  wire                               req_final_char,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [rdxc_pkg::CHAR_W-1:0]       rsp_out_char,
   output logic                              rsp_last_digit,
   output logic                              rsp_bad_input,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [rdxc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [rdxc_pkg::RADIX_W-1:0]      csr_wdata
);
   import rdxc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_LOAD,
      ST_SEND
   } state_type;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_BITS - 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(VALUE_BITS - 1);

   state_type state_ff, state_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic err_ff, err_in;
   logic [RADIX_W-1:0] src_radix_ff, src_radix_in;
   logic [RADIX_W-1:0] dst_radix_ff, dst_radix_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic rsp_last_ff, rsp_last_in;
   logic rsp_bad_ff, rsp_bad_in;

   logic [DIGIT_W-1:0] store [VALUE_BITS];
   logic [DIGIT_W-1:0] rd_data_ff;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DIGIT_W-1:0] wr_data;

   logic [RADIX_W-1:0] src_clamped;
   digit_type dec;
   logic [MAC_W-1:0] mac;
   logic char_err;
   logic err_next;
   logic [VALUE_BITS-1:0] acc_next;
   logic [RADIX_W-1:0] rem_sh;
   logic rem_ge;
   logic [RADIX_W-1:0] rem_new;
   logic [VALUE_BITS-1:0] quo_new;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;
   assign rsp_bad_input = rsp_bad_ff;

   // Character accumulate: one multiply-add with range check.
   always_comb begin
      src_clamped = clamp_radix(src_radix_ff);
      dec = decode_char(req_digit_char);
      mac = MAC_W'(acc_ff) * MAC_W'(src_clamped) + MAC_W'(dec.value);
      char_err = !dec.ok || (dec.value >= src_clamped) || (|mac[MAC_W-1:VALUE_BITS]);
      err_next = err_ff || char_err;
      acc_next = (err_ff || char_err) ? acc_ff : mac[VALUE_BITS-1:0];
   end

   // Shared restoring divide step: one quotient bit per cycle.
   always_comb begin
      rem_sh = {rem_ff[RADIX_W-2:0], quo_ff[VALUE_BITS-1]};
      rem_ge = (rem_sh >= div_ff);
      rem_new = rem_ge ? (rem_sh - div_ff) : rem_sh;
      quo_new = {quo_ff[VALUE_BITS-2:0], rem_ge};
   end

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      err_in = err_ff;
      src_radix_in = src_radix_ff;
      dst_radix_in = dst_radix_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      step_in = step_ff;
      cnt_in = cnt_ff;
      ptr_in = ptr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_bad_in = rsp_bad_ff;
      wr_en = 1'b0;
      wr_addr = cnt_ff[ADDR_W-1:0];
      wr_data = rem_new[DIGIT_W-1:0];

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SOURCE_RADIX: src_radix_in = csr_wdata;
            CSR_DEST_RADIX:   dst_radix_in = csr_wdata;
            default:          ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_final_char) begin
                  acc_in = acc_next;
                  err_in = err_next;
               end else begin
                  acc_in = '0;
                  err_in = 1'b0;
                  if (err_next) begin
                     rsp_valid_in = 1'b1;
                     rsp_char_in = '0;
                     rsp_last_in = 1'b1;
                     rsp_bad_in = 1'b1;
                     state_in = ST_SEND;
                  end else begin
                     quo_in = acc_next;
                     rem_in = '0;
                     step_in = '0;
                     cnt_in = '0;
                     div_in = clamp_radix(dst_radix_ff);
                     state_in = ST_DIVIDE;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            quo_in = quo_new;
            rem_in = rem_new;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               // remainder is the next digit, least significant first
               wr_en = 1'b1;
               rem_in = '0;
               step_in = '0;
               cnt_in = cnt_ff + CNT_W'(1);
               if (quo_new == '0 || cnt_ff == LAST_CNT) begin
                  ptr_in = cnt_ff[ADDR_W-1:0];
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_char_in = encode_digit(rd_data_ff);
            rsp_last_in = (ptr_ff == '0);
            rsp_bad_in = 1'b0;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff - ADDR_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         acc_ff <= '0;
         err_ff <= 1'b0;
         src_radix_ff <= RADIX_RESET;
         dst_radix_ff <= RADIX_RESET;
         step_ff <= '0;
         cnt_ff <= '0;
         ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff <= acc_in;
         err_ff <= err_in;
         src_radix_ff <= src_radix_in;
         dst_radix_ff <= dst_radix_in;
         step_ff <= step_in;
         cnt_ff <= cnt_in;
         ptr_ff <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   // Digit store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_data_ff <= store[ptr_ff];
   end

endmodule

`default_nettype wire

### rtl/rdxc_checker.sv
// Port-level checks for the radix converter, bound onto the top level.
`default_nettype none

module rdxc_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [rdxc_pkg::CHAR_W-1:0]   rsp_out_char,
   input wire                          rsp_last_digit,
   input wire                          rsp_bad_input
);
   import rdxc_pkg::*;

   // hold a word until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped before accept");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // one number in flight: no new character while a word is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while output pending");

   a_error_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_input |-> rsp_out_char == '0 && rsp_last_digit)
      else $error("error word malformed");

   a_digit_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_input |->
         (rsp_out_char >= ASCII_ZERO && rsp_out_char <= ASCII_NINE) ||
         (rsp_out_char >= ASCII_UPPER_A && rsp_out_char <= ASCII_TOP_DIGIT))
      else $error("output character is not a digit");

endmodule

bind radix_converter rdxc_checker u_rdxc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_char   (rsp_out_char),
   .rsp_last_digit (rsp_last_digit),
   .rsp_bad_input  (rsp_bad_input)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the radix converter: directed and random number streams.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rdxc_pkg::*;

   typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              bad;
   } out_word_type;

   typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              fin;
   } in_word_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   // Tracks the converter's value and flags and holds the digits it must emit.
   class radix_scoreboard;
      out_word_type      digits_due[$];
      logic [RADIX_W-1:0] src_reg = RADIX_RESET;
      logic [RADIX_W-1:0] dst_reg = RADIX_RESET;
      logic [63:0]       value = '0;
      bit                broken = 1'b0;
      int                mismatches = 0;
      int                words_checked = 0;
      int                numbers = 0;
      int                bad_numbers = 0;
      int                csr_writes = 0;

      function logic [63:0] fold(logic [RADIX_W-1:0] r);
         if (r < RADIX_W'(MIN_RADIX)) return 64'(MIN_RADIX);
         if (r > RADIX_W'(MAX_RADIX)) return 64'(MAX_RADIX);
         return 64'(r);
      endfunction

      // -1 for anything that is not a digit or an upper case letter
      function int char_value(logic [CHAR_W-1:0] c);
         if (c >= ASCII_ZERO && c <= ASCII_NINE) return int'(c - ASCII_ZERO);
         if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) return int'(c - LETTER_OFFSET);
         return -1;
      endfunction

      function logic [CHAR_W-1:0] digit_to_char(int d);
         if (d > 9) return CHAR_W'(d) + LETTER_OFFSET;
         return CHAR_W'(d) + ASCII_ZERO;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [RADIX_W-1:0] v);
         if (idx == CSR_SOURCE_RADIX) src_reg = v;
         else dst_reg = v;
         csr_writes++;
      endfunction

      function void note_input(logic [CHAR_W-1:0] ch, logic fin);
         logic [63:0] r;
         logic [63:0] v;
         logic [63:0] top;
         logic [4:0]  digs [64];
         int          d;
         int          n;
         out_word_type w;
         top = (64'd1 << VALUE_BITS) - 64'd1;
         if (!broken) begin
            r = fold(src_reg);
            d = char_value(ch);
            if (d < 0 || 64'(d) >= r) broken = 1'b1;
            else if (value > (top - 64'(d)) / r) broken = 1'b1;
            else value = value * r + 64'(d);
         end
         if (fin !== 1'b1) return;
         numbers++;
         if (broken) begin
            bad_numbers++;
            w.ch = '0;
            w.last = 1'b1;
            w.bad = 1'b1;
            digits_due.push_back(w);
         end else begin
            r = fold(dst_reg);
            v = value;
            n = 0;
            do begin
               digs[n] = 5'(v % r);
               v = v / r;
               n++;
            end while (v != 0);
            for (int k = n - 1; k >= 0; k--) begin
               w.ch = digit_to_char(int'(digs[k]));
               w.last = (k == 0);
               w.bad = 1'b0;
               digits_due.push_back(w);
            end
         end
         value = '0;
         broken = 1'b0;
      endfunction

      function void check_result(logic [CHAR_W-1:0] ch, logic last, logic bad);
         out_word_type w;
         words_checked++;
         if (digits_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word char=%h last=%b bad=%b", ch, last, bad));
            return;
         end
         w = digits_due.pop_front();
         if (ch !== w.ch)
            report_mismatch($sformatf("out_char %h, want %h", ch, w.ch));
         if (last !== w.last)
            report_mismatch($sformatf("last_digit %b, want %b", last, w.last));
         if (bad !== w.bad)
            report_mismatch($sformatf("bad_input %b, want %b", bad, w.bad));
      endfunction

      // print one line and count
      function void report_mismatch(string msg);
         mismatches++;
         $display("MISMATCH @%0t: %s", $realtime, msg);
      endfunction

      function int pending();
         return digits_due.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [CHAR_W-1:0]    req_digit_char;
   logic                 req_final_char;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [CHAR_W-1:0]    rsp_out_char;
   logic                 rsp_last_digit;
   logic                 rsp_bad_input;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [RADIX_W-1:0]   csr_wdata;

   radix_scoreboard sb = new();
   in_word_type     char_q[$];
   int              pushed_count = 0;
   int              accepted_count = 0;
   int              rsp_hold = 0;

   radix_converter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_digit_char (req_digit_char),
      .req_final_char (req_final_char),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_last_digit (rsp_last_digit),
      .rsp_bad_input  (rsp_bad_input),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // worst case: every item a 31-digit base-2 number, plus stalls
   initial begin
      #30ms;
      $display("tb: failure");
      $finish;
   end

   // character sender: bursts of random length separated by random gaps
   initial begin
      int burst_left;
      int gap_left;
      burst_left = 0;
      gap_left = 0;
      req_valid <= 1'b0;
      req_digit_char <= '0;
      req_final_char <= 1'b0;
      forever begin
         @(posedge clock);
         if (req_valid && req_ready) begin
            sb.note_input(req_digit_char, req_final_char);
            void'(char_q.pop_front());
            accepted_count++;
         end
         if (req_valid && !req_ready) begin
            // hold the word until taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (char_q.size() > 0) begin
            req_valid <= 1'b1;
            req_digit_char <= char_q[0].ch;
            req_final_char <= char_q[0].fin;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: stall pattern switches among open, coin-flip, sparse and periodic modes at random
   initial begin
      rx_mode_type rx_mode;
      int       rx_left;
      int       tick;
      rx_mode = RX_OPEN;
      rx_left = 0;
      tick = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_out_char, rsp_last_digit, rsp_bad_input);
         tick++;
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            if (rx_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 3));
               rx_left = $urandom_range(16, 160);
            end
            rx_left--;
            case (rx_mode)
               RX_OPEN: rsp_ready <= 1'b1;
               RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 4) == 0);
               default: rsp_ready <= ((tick % 5) < 3);
            endcase
         end
      end
   end

   task automatic push_item(logic [CHAR_W-1:0] ch, logic fin);
      in_word_type w;
      w.ch = ch;
      w.fin = fin;
      char_q.push_back(w);
      pushed_count++;
   endtask

   // last character of the string is marked final
   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_item(s[i], i == s.len() - 1);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [RADIX_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, v);
      csr_valid <= 1'b0;
   endtask

   // wait for all characters taken and all digits out, then let the block settle
   task automatic wait_quiet();
      while (accepted_count != pushed_count || sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic int digits_for(int r);
      logic [63:0] v;
      int          n;
      v = (64'd1 << VALUE_BITS) - 64'd1;
      n = 0;
      while (v != 0) begin
         v = v / 64'(r);
         n++;
      end
      return n;
   endfunction

   function automatic logic [RADIX_W-1:0] pick_radix();
      int k;
      k = $urandom_range(0, 9);
      if (k < 2) return RADIX_W'($urandom_range(0, 63));
      if (k < 4) begin
         case ($urandom_range(0, 5))
            0: return RADIX_W'(0);
            1: return RADIX_W'(1);
            2: return RADIX_W'(MIN_RADIX);
            3: return RADIX_W'(MAX_RADIX);
            4: return RADIX_W'(33);
            default: return RADIX_W'(63);
         endcase
      end
      return RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
   endfunction

   task automatic add_number(inout int used);
      int r;
      int maxlen;
      int len;
      int kind;
      int d;
      r = int'(sb.fold(sb.src_reg));
      maxlen = digits_for(r);
      kind = $urandom_range(0, 99);
      if (kind < 88) begin
         if (kind < 70)
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, maxlen)
                                              : $urandom_range(1, (maxlen < 4) ? maxlen : 4);
         else if (kind < 80)
            len = maxlen + $urandom_range(0, 1);  // near or past the value range
         else
            len = $urandom_range(1, 3);
         for (int i = 0; i < len; i++) begin
            d = (kind >= 80) ? 0 : $urandom_range(0, r - 1);
            push_item(sb.digit_to_char(d), i == len - 1);
         end
         used += len;
      end else begin
         // noise: stray bytes, in-radix and out-of-radix digit characters, sometimes left unterminated
         len = $urandom_range(1, 4);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
               0, 1: push_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
               2: push_item(sb.digit_to_char($urandom_range(0, r - 1)), 1'b0);
               default: push_item(sb.digit_to_char($urandom_range(r, 35)), 1'b0);
            endcase
         end
         if ($urandom_range(0, 3) != 0) char_q[$].fin = 1'b1;
         used += len;
      end
   endtask

   initial begin
      int used;
      int phase_used;
      int phase;
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= CSR_SOURCE_RADIX;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: zero, too-large digit, invalid character then ignored ones, byte extremes
      push_text("0");
      push_text("A");
      push_item("1", 1'b0);
      push_item(8'h40, 1'b0);
      push_item("5", 1'b1);
      push_text("7");
      push_item(8'hFF, 1'b1);
      push_item(8'h00, 1'b1);
      wait_quiet();
      // radix registers past both ends fold to 32 and 2
      write_reg(CSR_SOURCE_RADIX, RADIX_W'(63));
      write_reg(CSR_DEST_RADIX, RADIX_W'(1));
      push_text("1VVVVVV");
      push_text("2000000");
      push_text("Z");
      wait_quiet();
      // change the source radix in the middle of a number
      write_reg(CSR_SOURCE_RADIX, RADIX_W'(0));
      write_reg(CSR_DEST_RADIX, RADIX_W'(33));
      push_item("1", 1'b0);
      push_item("1", 1'b0);
      wait_quiet();
      write_reg(CSR_SOURCE_RADIX, RADIX_W'(MAX_RADIX));
      push_item("V", 1'b1);
      wait_quiet();

      used = 0;
      phase = 0;
      while (used < 360) begin
         write_reg(CSR_SOURCE_RADIX, pick_radix());
         write_reg(CSR_DEST_RADIX, pick_radix());
         // starve the output so the block backs up onto its input
         if (phase == 2) rsp_hold = 400;
         phase_used = 0;
         while (phase_used < 30) add_number(phase_used);
         used += phase_used;
         wait_quiet();
         phase++;
      end

      wait_quiet();
      repeat (40) @(posedge clock);
      if (sb.pending() != 0) sb.report_mismatch("digits still due at end of run");
      $display("covered %0d numbers (%0d flagged bad) over %0d phases, %0d register writes",
               sb.numbers, sb.bad_numbers, phase + 4, sb.csr_writes);
      $display("checked %0d result words, %0d mismatches", sb.words_checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
